[hw/rtl/eirn_pkg.sv]
// shared constants, codes and helpers for the impulse response norm block
// no dependencies
package eirn_pkg;

	localparam int OPCODE_W = 2;
	localparam int INDEX_W  = 4;
	localparam int VALUE_W  = 32;
	localparam int NORM_W   = 32;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [OPCODE_W-1:0] OP_WR_A = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_WR_B = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_WR_C = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_RUN  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SAT   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_STATE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FINAL_TIME  = 2'd2;

	function automatic logic is_sat32(input logic signed [63:0] v);
		is_sat32 = (v > 64'sh7FFF_FFFF) || (v < -64'sh8000_0000);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sh8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		sat32 = r;
	endfunction

endpackage

[hw/rtl/eirn_if.sv]
// valid/ready channel interfaces for item, result and configuration words
// depends on eirn_pkg
interface eirn_item_if;
	logic valid;
	logic ready;
	logic [eirn_pkg::OPCODE_W-1:0] opcode;
	logic [eirn_pkg::INDEX_W-1:0] row;
	logic [eirn_pkg::INDEX_W-1:0] column;
	logic signed [eirn_pkg::VALUE_W-1:0] value;
	modport source(output valid, opcode, row, column, value, input ready);
	modport sink(input valid, opcode, row, column, value, output ready);
endinterface

interface eirn_result_if;
	logic valid;
	logic ready;
	logic [eirn_pkg::NORM_W-1:0] norm;
	logic [eirn_pkg::STATUS_W-1:0] status;
	modport source(output valid, norm, status, input ready);
	modport sink(input valid, norm, status, output ready);
endinterface

interface eirn_cfg_if;
	logic valid;
	logic ready;
	logic [eirn_pkg::CFG_IDX_W-1:0] index;
	logic [eirn_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[hw/rtl/euler_impulse_response_norm.sv]
// Forward Euler impulse response norm of a single-input single-output state-space model.
// Loads are accepted while idle. A run passes through a step division, initial state setup, the
// Euler steps and a square root, sequenced around one shared 33x33 multiplier and model memories
// with one read port each; a run with zero steps goes straight to the result state.
// No item is taken while a run is in progress.
// depends on eirn_pkg and eirn_if
module euler_impulse_response_norm #(
	parameter int MAX_STATES = 16,
	parameter int FRACTION_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	eirn_item_if.sink req,
	eirn_result_if.source rsp,
	eirn_cfg_if.sink cfg
);
	import eirn_pkg::*;

	localparam int IW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
	localparam int CW = $clog2(MAX_STATES + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIV  = 4'd1;
	localparam logic [3:0] S_INIT = 4'd2;
	localparam logic [3:0] S_YDOT = 4'd3;
	localparam logic [3:0] S_YSQ  = 4'd4;
	localparam logic [3:0] S_YSQW = 4'd5;
	localparam logic [3:0] S_TLO  = 4'd6;
	localparam logic [3:0] S_THI  = 4'd7;
	localparam logic [3:0] S_TADD = 4'd8;
	localparam logic [3:0] S_EADD = 4'd9;
	localparam logic [3:0] S_DX   = 4'd10;
	localparam logic [3:0] S_XUPD = 4'd11;
	localparam logic [3:0] S_SQRT = 4'd12;
	localparam logic [3:0] S_DONE = 4'd13;

	logic [3:0] state_q;
	logic [1:0] ph_q;
	logic [5:0] cnt_q;
	logic [CW-1:0] i_q, j_q, n_q;
	logic [19:0] step_q;

	logic [4:0] state_count_q;
	logic [19:0] step_count_q;
	logic [30:0] final_time_q;

	logic signed [31:0] a_mem [2**(2*IW)];
	logic signed [31:0] b_mem [2**IW];
	logic signed [31:0] c_mem [2**IW];
	logic signed [31:0] x_mem [2**IW];
	logic signed [31:0] dx_mem [2**IW];
	logic signed [31:0] a_rd_q, b_rd_q, c_rd_q, x_rd_q, dx_rd_q;

	logic [30:0] dt_q;
	logic [19:0] div_rem_q;
	logic signed [31:0] y_q;
	logic [62:0] yy_q;
	logic [95:0] p_q;
	logic [63:0] energy_q;
	logic sat_q;
	logic signed [63:0] acc_q;
	logic [63:0] v_q;
	logic [35:0] sq_rem_q;
	logic [31:0] root_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_q;

	logic [NORM_W-1:0] norm_q;
	logic [STATUS_W-1:0] status_q;
	logic rsp_valid_q;

	logic [IW+3:0] row_x, col_x;
	logic [IW-1:0] wr_row, wr_col, ii, jj, x_raddr;
	logic row_ok, col_ok, acc_item;
	logic [CW-1:0] n_cfg, i_nx, j_nx;
	logic signed [63:0] prod_sh, acc_nx, x_sum;
	logic [20:0] div_sh;
	logic [35:0] sq_sh, sq_trial;
	logic [63:0] term;
	logic term_sat;
	logic [64:0] e_sum;
	logic x_we, dx_we;
	logic signed [31:0] x_wd, dx_wd;

	assign row_x = {{IW{1'b0}}, req.row};
	assign col_x = {{IW{1'b0}}, req.column};
	assign wr_row = row_x[IW-1:0];
	assign wr_col = col_x[IW-1:0];
	assign row_ok = 32'(req.row) < MAX_STATES;
	assign col_ok = 32'(req.column) < MAX_STATES;
	assign acc_item = req.valid && req.ready;
	assign ii = i_q[IW-1:0];
	assign jj = j_q[IW-1:0];
	assign i_nx = CW'(i_q + 1'b1);
	assign j_nx = CW'(j_q + 1'b1);
	assign n_cfg = (32'(state_count_q) > MAX_STATES) ? CW'(MAX_STATES) : CW'(state_count_q);

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.norm = norm_q;
	assign rsp.status = status_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_count_q <= 5'd1;
			step_count_q <= '0;
			final_time_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_STATE_COUNT: state_count_q <= cfg.data[4:0];
				REG_STEP_COUNT: step_count_q <= cfg.data[19:0];
				REG_FINAL_TIME: final_time_q <= cfg.data[30:0];
				default: ;
			endcase
		end
	end

	// model memories
	assign x_raddr = (state_q == S_DX) ? jj : ii;

	always_ff @(posedge clk) begin
		if (acc_item && req.opcode == OP_WR_A && row_ok && col_ok) begin
			a_mem[{wr_row, wr_col}] <= req.value;
		end
		a_rd_q <= a_mem[{ii, jj}];
	end

	always_ff @(posedge clk) begin
		if (acc_item && req.opcode == OP_WR_B && row_ok) begin
			b_mem[wr_row] <= req.value;
		end
		b_rd_q <= b_mem[ii];
	end

	always_ff @(posedge clk) begin
		if (acc_item && req.opcode == OP_WR_C && row_ok) begin
			c_mem[wr_row] <= req.value;
		end
		c_rd_q <= c_mem[ii];
	end

	always_ff @(posedge clk) begin
		if (x_we) begin
			x_mem[ii] <= x_wd;
		end
		x_rd_q <= x_mem[x_raddr];
	end

	always_ff @(posedge clk) begin
		if (dx_we) begin
			dx_mem[ii] <= dx_wd;
		end
		dx_rd_q <= dx_mem[ii];
	end

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_INIT: begin
				mul_a = 33'(b_rd_q);
				mul_b = {2'b00, dt_q};
			end
			S_YDOT: begin
				mul_a = 33'(c_rd_q);
				mul_b = 33'(x_rd_q);
			end
			S_DX: begin
				mul_a = 33'(a_rd_q);
				mul_b = 33'(x_rd_q);
			end
			S_XUPD: begin
				mul_a = 33'(dx_rd_q);
				mul_b = {2'b00, dt_q};
			end
			S_YSQ: begin
				mul_a = 33'(y_q);
				mul_b = 33'(y_q);
			end
			S_TLO: begin
				mul_a = {1'b0, yy_q[31:0]};
				mul_b = {2'b00, dt_q};
			end
			S_THI: begin
				mul_a = {2'b00, yy_q[62:32]};
				mul_b = {2'b00, dt_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// datapath helpers
	assign prod_sh = 64'(prod_q >>> FRACTION_BITS);
	assign acc_nx = acc_q + prod_sh;
	assign x_sum = 64'(x_rd_q) + prod_sh;
	assign div_sh = {div_rem_q, dt_q[30]};
	assign sq_sh = {sq_rem_q[33:0], v_q[63:62]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign term = 64'(p_q >> FRACTION_BITS);
	assign term_sat = (p_q >> (64 + FRACTION_BITS)) != '0;
	assign e_sum = {1'b0, energy_q} + {1'b0, term};

	always_comb begin
		x_we = 1'b0;
		x_wd = '0;
		dx_we = 1'b0;
		dx_wd = '0;
		if (ph_q == 2'd2) begin
			unique case (state_q)
				S_INIT: begin
					x_we = 1'b1;
					x_wd = sat32(prod_sh);
				end
				S_XUPD: begin
					x_we = 1'b1;
					x_wd = sat32(x_sum);
				end
				S_DX: begin
					dx_we = (j_nx == n_q);
					dx_wd = sat32(acc_nx);
				end
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q <= '0;
			cnt_q <= '0;
			i_q <= '0;
			j_q <= '0;
			n_q <= '0;
			step_q <= '0;
			sat_q <= 1'b0;
			energy_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc_item && req.opcode == OP_RUN) begin
						sat_q <= 1'b0;
						energy_q <= '0;
						i_q <= '0;
						j_q <= '0;
						ph_q <= '0;
						step_q <= '0;
						cnt_q <= '0;
						n_q <= n_cfg;
						if (step_count_q == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					cnt_q <= 6'(cnt_q + 1'b1);
					if (cnt_q == 6'd30) begin
						cnt_q <= '0;
						state_q <= (n_q == '0) ? S_SQRT : S_INIT;
					end
				end
				S_INIT, S_YDOT, S_DX, S_XUPD: begin
					ph_q <= 2'(ph_q + 1'b1);
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						if (x_we && is_sat32(state_q == S_XUPD ? x_sum : prod_sh)) begin
							sat_q <= 1'b1;
						end
						unique case (state_q)
							S_INIT: begin
								i_q <= i_nx;
								if (i_nx == n_q) begin
									i_q <= '0;
									state_q <= S_YDOT;
								end
							end
							S_YDOT: begin
								i_q <= i_nx;
								if (i_nx == n_q) begin
									i_q <= '0;
									if (is_sat32(acc_nx)) begin
										sat_q <= 1'b1;
									end
									state_q <= S_YSQ;
								end
							end
							S_DX: begin
								j_q <= j_nx;
								if (j_nx == n_q) begin
									j_q <= '0;
									if (is_sat32(acc_nx)) begin
										sat_q <= 1'b1;
									end
									i_q <= i_nx;
									if (i_nx == n_q) begin
										i_q <= '0;
										state_q <= S_XUPD;
									end
								end
							end
							default: begin
								i_q <= i_nx;
								if (i_nx == n_q) begin
									i_q <= '0;
									step_q <= 20'(step_q + 1'b1);
									if (20'(step_q + 1'b1) == step_count_q) begin
										state_q <= S_SQRT;
									end else begin
										state_q <= S_YDOT;
									end
								end
							end
						endcase
					end
				end
				S_YSQ: state_q <= S_YSQW;
				S_YSQW: state_q <= S_TLO;
				S_TLO: state_q <= S_THI;
				S_THI: state_q <= S_TADD;
				S_TADD: state_q <= S_EADD;
				S_EADD: begin
					if (term_sat || e_sum[64]) begin
						sat_q <= 1'b1;
						energy_q <= '1;
					end else begin
						energy_q <= e_sum[63:0];
					end
					state_q <= S_DX;
				end
				S_SQRT: begin
					cnt_q <= 6'(cnt_q + 1'b1);
					if (cnt_q == 6'd31) begin
						cnt_q <= '0;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				dt_q <= final_time_q;
				div_rem_q <= '0;
				acc_q <= '0;
			end
			S_DIV: begin
				if (div_sh >= {1'b0, step_count_q}) begin
					div_rem_q <= 20'(div_sh - {1'b0, step_count_q});
					dt_q <= {dt_q[29:0], 1'b1};
				end else begin
					div_rem_q <= div_sh[19:0];
					dt_q <= {dt_q[29:0], 1'b0};
				end
				v_q <= '0;
				sq_rem_q <= '0;
				root_q <= '0;
			end
			S_YDOT, S_DX: begin
				if (ph_q == 2'd2) begin
					acc_q <= acc_nx;
					if (state_q == S_YDOT ? (i_nx == n_q) : (j_nx == n_q)) begin
						acc_q <= '0;
					end
					if (state_q == S_YDOT && i_nx == n_q) begin
						y_q <= sat32(acc_nx);
					end
				end
			end
			S_XUPD: begin
				v_q <= energy_q;
				sq_rem_q <= '0;
				root_q <= '0;
			end
			S_YSQW: yy_q <= prod_q[62:0];
			S_THI: p_q <= {30'd0, prod_q};
			S_TADD: p_q <= p_q + {prod_q[63:0], 32'd0};
			S_EADD: begin
				v_q <= (term_sat || e_sum[64]) ? '1 : e_sum[63:0];
				sq_rem_q <= '0;
				root_q <= '0;
			end
			S_SQRT: begin
				v_q <= {v_q[61:0], 2'b00};
				if (sq_sh >= sq_trial) begin
					sq_rem_q <= sq_sh - sq_trial;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					sq_rem_q <= sq_sh;
					root_q <= {root_q[30:0], 1'b0};
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					if (step_count_q == '0) begin
						norm_q <= '0;
						status_q <= ST_EMPTY;
					end else begin
						norm_q <= root_q;
						status_q <= sat_q ? ST_SAT : ST_OK;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

[sim/euler_impulse_response_norm_tb.sv]
// testbench for euler_impulse_response_norm: loads, runs and register writes checked against
// an in-bench fixed point Euler predictor, with random stalls on both sides
// depends on eirn_pkg, eirn_if and the block itself
module euler_impulse_response_norm_tb;
	import eirn_pkg::*;

	localparam int NST = 16;
	localparam int FB = 16;
	localparam longint CYCLE_LIMIT = 6000000;

	typedef struct {
		logic is_cfg;
		logic [OPCODE_W-1:0] opcode;
		logic [INDEX_W-1:0] row;
		logic [INDEX_W-1:0] column;
		logic [VALUE_W-1:0] value;
		logic [CFG_IDX_W-1:0] cidx;
		logic [CFG_DATA_W-1:0] cdata;
	} word_t;

	typedef struct {
		logic [NORM_W-1:0] norm;
		logic [STATUS_W-1:0] status;
	} norm_t;

	logic clk;
	logic arst_n;
	eirn_item_if req();
	eirn_result_if rsp();
	eirn_cfg_if cfg();

	euler_impulse_response_norm #(.MAX_STATES(NST), .FRACTION_BITS(FB)) uut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
	);

	word_t pending_words[$];
	norm_t expected_norms[$];
	logic signed [31:0] mat_mem [NST*NST];
	logic signed [31:0] b_mem [NST];
	logic signed [31:0] c_mem [NST];
	logic [4:0] n_reg;
	logic [19:0] steps_reg;
	logic [30:0] ft_reg;
	logic sat_flag;
	int errors;
	int quiet;
	int sent;
	int taken;
	longint cycles;
	logic calm;
	word_t cur;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	function automatic longint shr_fb(input longint v);
		shr_fb = v >>> FB;
	endfunction

	function automatic logic signed [31:0] clip32(input longint v);
		logic signed [31:0] r;
		if (v > 64'sh7FFF_FFFF) begin
			sat_flag = 1'b1;
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sh8000_0000) begin
			sat_flag = 1'b1;
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [63:0] root64(input logic [63:0] v0);
		logic [63:0] v, r, b;
		v = v0;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic predict_norm(output norm_t res);
		logic signed [31:0] x [NST];
		logic signed [31:0] dx [NST];
		logic [63:0] energy, yy, term;
		logic [127:0] prod;
		logic signed [31:0] y;
		longint dt, acc;
		int n;
		if (steps_reg == 0) begin
			res.norm = 0;
			res.status = ST_EMPTY;
			return;
		end
		sat_flag = 1'b0;
		n = (n_reg > NST) ? NST : n_reg;
		dt = longint'(ft_reg / steps_reg);
		for (int i = 0; i < NST; i++) begin
			x[i] = 0;
			dx[i] = 0;
		end
		energy = 0;
		for (int i = 0; i < n; i++) x[i] = clip32(shr_fb(longint'(b_mem[i]) * dt));
		for (int k = 0; k < steps_reg; k++) begin
			acc = 0;
			for (int i = 0; i < n; i++) acc += shr_fb(longint'(c_mem[i]) * longint'(x[i]));
			y = clip32(acc);
			yy = longint'(y) * longint'(y);
			prod = ({64'd0, yy} * {64'd0, dt[63:0]}) >> FB;
			if (prod[127:64] != 0) begin
				sat_flag = 1'b1;
				term = '1;
			end else begin
				term = prod[63:0];
			end
			if (energy + term < energy) begin
				sat_flag = 1'b1;
				energy = '1;
			end else begin
				energy = energy + term;
			end
			for (int i = 0; i < n; i++) begin
				acc = 0;
				for (int j = 0; j < n; j++)
					acc += shr_fb(longint'(mat_mem[i*NST+j]) * longint'(x[j]));
				dx[i] = clip32(acc);
			end
			for (int i = 0; i < n; i++)
				x[i] = clip32(longint'(x[i]) + shr_fb(longint'(dx[i]) * dt));
		end
		res.norm = root64(energy);
		res.status = sat_flag ? ST_SAT : ST_OK;
	endtask

	task automatic take_word(input word_t w);
		norm_t r;
		case (w.opcode)
			OP_WR_A: mat_mem[w.row*NST+w.column] = w.value;
			OP_WR_B: b_mem[w.row] = w.value;
			OP_WR_C: c_mem[w.row] = w.value;
			default: begin
				predict_norm(r);
				expected_norms.push_back(r);
			end
		endcase
	endtask

	task automatic push_item(input logic [1:0] op, input logic [3:0] r, input logic [3:0] c,
			input logic [31:0] v);
		word_t w;
		w.is_cfg = 1'b0;
		w.opcode = op;
		w.row = r;
		w.column = c;
		w.value = v;
		w.cidx = 0;
		w.cdata = 0;
		pending_words.push_back(w);
		sent++;
	endtask

	task automatic push_cfg(input logic [1:0] idx, input logic [31:0] d);
		word_t w;
		w.is_cfg = 1'b1;
		w.opcode = OP_WR_A;
		w.row = 0;
		w.column = 0;
		w.value = 0;
		w.cidx = idx;
		w.cdata = d;
		pending_words.push_back(w);
	endtask

	task automatic push_setting(input int n, input int st, input logic [30:0] ft);
		push_cfg(REG_STATE_COUNT, {27'($urandom_range(0, 32'h07FF_FFFF)), n[4:0]});
		push_cfg(REG_STEP_COUNT, {12'($urandom_range(0, 4095)), st[19:0]});
		push_cfg(REG_FINAL_TIME, {1'($urandom_range(0, 1)), ft});
	endtask

	function automatic logic [31:0] rand_value();
		int p;
		logic [31:0] m;
		p = $urandom_range(0, 99);
		if (p < 60) m = $urandom_range(0, 32'h2_0000);
		else if (p < 85) m = $urandom_range(0, 32'h1000);
		else return $urandom;
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	function automatic logic [30:0] rand_ft();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70) return 31'($urandom_range(0, 32'h4_0000));
		if (p < 90) return 31'($urandom_range(0, 32'h40_0000));
		return 31'($urandom);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycles <= 0;
		end else begin
			cycles <= cycles + 1;
			if (cycles >= CYCLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	assign calm = (taken > 500) && (taken < 700);

	// driver
	always @(posedge clk or negedge arst_n) begin
		logic busy_i, busy_c;
		int q;
		word_t nx;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.opcode <= OP_WR_A;
			req.row <= 0;
			req.column <= 0;
			req.value <= 0;
			cfg.valid <= 1'b0;
			cfg.index <= REG_STATE_COUNT;
			cfg.data <= 0;
			quiet <= 0;
		end else begin
			busy_i = req.valid;
			busy_c = cfg.valid;
			q = quiet + 1;
			if (req.valid && req.ready) begin
				take_word(cur);
				taken++;
				busy_i = 1'b0;
				q = 0;
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_STATE_COUNT: n_reg = cfg.data[4:0];
					REG_STEP_COUNT: steps_reg = cfg.data[19:0];
					REG_FINAL_TIME: ft_reg = cfg.data[30:0];
					default: ;
				endcase
				busy_c = 1'b0;
				q = 0;
			end
			if (rsp.valid && rsp.ready) q = 0;
			if (!busy_i && !busy_c && pending_words.size() > 0 &&
					(calm || $urandom_range(0, 99) >= 38)) begin
				nx = pending_words[0];
				if (nx.is_cfg) begin
					if (expected_norms.size() == 0 && q >= 16) begin
						void'(pending_words.pop_front());
						busy_c = 1'b1;
						cfg.index <= nx.cidx;
						cfg.data <= nx.cdata;
					end
				end else begin
					void'(pending_words.pop_front());
					busy_i = 1'b1;
					cur = nx;
					req.opcode <= nx.opcode;
					req.row <= nx.row;
					req.column <= nx.column;
					req.value <= nx.value;
				end
			end
			req.valid <= busy_i;
			cfg.valid <= busy_c;
			quiet <= q;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		norm_t e;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_norms.size() == 0) begin
					report("unexpected word", rsp.norm, 0);
				end else begin
					e = expected_norms.pop_front();
					if (rsp.norm !== e.norm) report("norm", rsp.norm, e.norm);
					if (rsp.status !== e.status) report("status", rsp.status, e.status);
				end
			end
			rsp.ready <= calm || ($urandom_range(0, 99) >= 38);
		end
	end

	initial begin
		int n, st, p, k, eff, last_n;
		errors = 0;
		sent = 0;
		taken = 0;
		last_n = 1;
		n_reg = 1;
		steps_reg = 0;
		ft_reg = 0;
		arst_n = 1'b0;

		// every model entry loaded first so no run reads an unwritten one
		for (int i = 0; i < NST; i++)
			for (int j = 0; j < NST; j++) push_item(OP_WR_A, 4'(i), 4'(j), rand_value());
		for (int i = 0; i < NST; i++) begin
			push_item(OP_WR_B, 4'(i), 4'($urandom), rand_value());
			push_item(OP_WR_C, 4'(i), 4'($urandom), rand_value());
		end

		// directed
		push_item(OP_RUN, 0, 0, 0);
		push_setting(1, 1, 31'h1_0000);
		push_item(OP_WR_A, 0, 0, 32'hFFFF_0000);
		push_item(OP_WR_B, 0, 15, 32'h0001_0000);
		push_item(OP_WR_C, 0, 15, 32'h0001_0000);
		push_item(OP_RUN, 15, 15, 32'hFFFF_FFFF);
		push_setting(0, 3, 31'h2_0000);
		push_item(OP_RUN, 0, 0, 0);
		push_setting(31, 2, 31'h8000);
		push_item(OP_RUN, 0, 0, 0);
		push_cfg(REG_STEP_COUNT, 32'hFFFF_FFFF);
		push_cfg(2'd3, 32'hFFFF_FFFF);
		push_cfg(REG_STEP_COUNT, 32'd0);
		push_item(OP_RUN, 0, 0, 0);
		push_item(OP_WR_B, 1, 0, 32'h7FFF_FFFF);
		push_item(OP_WR_C, 1, 0, 32'h8000_0000);
		push_item(OP_WR_A, 1, 1, 32'h7FFF_FFFF);
		push_item(OP_WR_A, 15, 15, 32'h8000_0000);
		push_setting(2, 1, 31'h7FFF_FFFF);
		push_item(OP_RUN, 0, 0, 0);
		push_setting(16, 1, 31'h7FFF_FFFF);
		push_item(OP_RUN, 0, 0, 0);
		push_item(OP_WR_A, 0, 0, 32'hFFFF_F000);
		push_item(OP_WR_B, 0, 0, 32'h0000_8000);
		push_setting(1, 3000, 31'h0400_0000);
		push_item(OP_RUN, 0, 0, 0);

		// random sequences: settings, a few loads, then a run, or a few loads alone
		while (sent < 1350) begin
			p = $urandom_range(0, 99);
			if (p < 85) begin
				k = $urandom_range(0, 99);
				if (k < 70) n = $urandom_range(1, 4);
				else if (k < 80) n = $urandom_range(5, 16);
				else if (k < 85) n = 0;
				else if (k < 90) n = $urandom_range(17, 31);
				else n = last_n;
				last_n = n;
				eff = (n > NST) ? NST : n;
				k = $urandom_range(0, 99);
				if (eff > 8) st = $urandom_range(1, 3);
				else if (k < 10) st = 0;
				else if (k < 80 || eff > 2) st = $urandom_range(1, 20);
				else st = $urandom_range(21, 200);
				if ($urandom_range(0, 9) == 0) push_cfg(2'd3, $urandom);
				push_setting(n, st, rand_ft());
				k = $urandom_range(0, 12);
				for (int i = 0; i < k; i++)
					push_item(2'($urandom_range(0, 2)), 4'($urandom), 4'($urandom),
						rand_value());
				push_item(OP_RUN, 4'($urandom), 4'($urandom), $urandom);
			end else begin
				k = $urandom_range(1, 6);
				for (int i = 0; i < k; i++)
					push_item(2'($urandom_range(0, 2)), 4'($urandom), 4'($urandom),
						$urandom);
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_words.size() != 0 || req.valid || cfg.valid || expected_norms.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/eirn_pkg.sv
hw/rtl/eirn_if.sv
hw/rtl/euler_impulse_response_norm.sv
sim/euler_impulse_response_norm_tb.sv
